// ===== hw/rtl/sparse_min_max_feature_scaler_top_assert.svh =====
// Assertion macros used by the scaler back end.
`ifndef SPARSE_MIN_MAX_FEATURE_SCALER_TOP_ASSERT_SVH
`define SPARSE_MIN_MAX_FEATURE_SCALER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SMS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define SMS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SMS_ASSERT_IMP(lbl, ante, cons, msg)
`define SMS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/sms_pkg.sv =====
// Types, codes and constants of the sparse min-max feature scaler.
package sms_pkg;
	localparam int DEF_FEATURE_SLOTS = 64;
	localparam int QUEUE_DEPTH = 4;

	localparam logic signed [31:0] I32_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] I32_MAX = 32'sh7fff_ffff;

	localparam logic [2:0] KIND_CLEAR       = 3'd0;
	localparam logic [2:0] KIND_SCAN_ELEM   = 3'd1;
	localparam logic [2:0] KIND_GATH_LABEL  = 3'd2;
	localparam logic [2:0] KIND_GATH_ELEM   = 3'd3;
	localparam logic [2:0] KIND_GATH_END    = 3'd4;
	localparam logic [2:0] KIND_SCALE_LABEL = 3'd5;
	localparam logic [2:0] KIND_SCALE_ELEM  = 3'd6;
	localparam logic [2:0] KIND_SCALE_END   = 3'd7;

	localparam logic [2:0] REG_RANGE_LOW  = 3'd0;
	localparam logic [2:0] REG_RANGE_HIGH = 3'd1;
	localparam logic [2:0] REG_LABEL_ON   = 3'd2;
	localparam logic [2:0] REG_LABEL_LOW  = 3'd3;
	localparam logic [2:0] REG_LABEL_HIGH = 3'd4;

	typedef enum logic [2:0] {
		OP_CLR,
		OP_WIDEN,
		OP_EMIT,
		OP_LGATH,
		OP_LSCALE
	} op_kind_t;

	typedef struct packed {
		logic [2:0]         kind;
		logic [5:0]         feature_index;
		logic signed [31:0] value;
	} in_item_t;

	typedef struct packed {
		logic [5:0]         out_index;
		logic signed [31:0] out_value;
		logic               is_label;
		logic               last;
	} out_item_t;

	typedef struct packed {
		op_kind_t           kind;
		logic [5:0]         slot;
		logic signed [31:0] value;
		logic               fin;
	} op_t;

	typedef struct packed {
		logic signed [31:0] range_low;
		logic signed [31:0] range_high;
		logic               label_scaling_on;
		logic signed [31:0] label_low;
		logic signed [31:0] label_high;
	} cfg_t;
endpackage

// ===== hw/rtl/sparse_min_max_feature_scaler_top.sv =====
// Top level of the sparse min-max feature scaler: configuration registers and the two ends.
//
//   channel  signals                        direction
//   req      req_valid req_ready req        into the block
//   rsp      rsp_valid rsp_ready rsp        out of the block
//   cfg      cfg_we cfg_idx cfg_data        into the block, write only
//
// The front takes an item when idle and then issues one table operation per cycle unless
// the queue is full, one per feature slot including skipped gaps. The back updates a bound
// in its read state and scales a value with its shift-add multiplier and its
// one-bit-per-cycle divider. Reset clears indices, bound tables and the queue.
// The queue of four operations lets the front keep expanding while the back stalls
// on a full result register.
module sparse_min_max_feature_scaler_top #(
	parameter int FEATURE_SLOTS = sms_pkg::DEF_FEATURE_SLOTS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  sms_pkg::in_item_t  req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output sms_pkg::out_item_t rsp,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_idx,
	input  logic [31:0]        cfg_data
);
	import sms_pkg::*;

	cfg_t cfg_q;
	logic f_valid;
	logic f_ready;
	op_t  f_op;
	logic b_valid;
	logic b_ready;
	op_t  b_op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.range_low <= 32'sd0;
			cfg_q.range_high <= 32'sd65536;
			cfg_q.label_scaling_on <= 1'b0;
			cfg_q.label_low <= 32'sd0;
			cfg_q.label_high <= 32'sd65536;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_RANGE_LOW:  cfg_q.range_low <= cfg_data;
				REG_RANGE_HIGH: cfg_q.range_high <= cfg_data;
				REG_LABEL_ON:   cfg_q.label_scaling_on <= cfg_data[0];
				REG_LABEL_LOW:  cfg_q.label_low <= cfg_data;
				REG_LABEL_HIGH: cfg_q.label_high <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	sms_front #(.FEATURE_SLOTS(FEATURE_SLOTS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.op_valid  (f_valid),
		.op_ready  (f_ready),
		.op        (f_op)
	);

	sms_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_op    (f_op),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_op     (b_op)
	);

	sms_back #(.FEATURE_SLOTS(FEATURE_SLOTS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.op_valid  (b_valid),
		.op_ready  (b_ready),
		.op        (b_op),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);
endmodule

// ===== hw/rtl/sms_front.sv =====
// Front end: accepts items, tracks indices and expands items into table operations.
module sms_front #(
	parameter int FEATURE_SLOTS = sms_pkg::DEF_FEATURE_SLOTS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  sms_pkg::in_item_t req,
	output logic              op_valid,
	input  logic              op_ready,
	output sms_pkg::op_t      op
);
	import sms_pkg::*;

	localparam logic [6:0] SLOTS7 = 7'(FEATURE_SLOTS);

	typedef enum logic [1:0] {
		F_IDLE = 2'b01,
		F_EMIT = 2'b10
	} fstate_t;

	fstate_t            st_q;
	logic [5:0]         highest_q;
	logic [6:0]         expect_q;
	logic [5:0]         cur_q;
	logic [5:0]         stop_q;
	op_kind_t           kind_q;
	logic signed [31:0] val_q;
	logic               accept;
	logic               idx_ok;
	logic               in_range;
	logic               at_stop;

	assign req_ready = (st_q == F_IDLE);
	assign accept = req_valid && req_ready;
	assign in_range = {1'b0, req.feature_index} < SLOTS7;
	assign idx_ok = in_range && (req.feature_index != 6'd0) &&
		(req.feature_index <= highest_q);
	assign at_stop = (cur_q == stop_q);

	assign op_valid = (st_q == F_EMIT);
	assign op.kind = kind_q;
	assign op.slot = cur_q;
	assign op.value = at_stop ? val_q : 32'sd0;
	assign op.fin = at_stop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= F_IDLE;
			highest_q <= '0;
			expect_q <= 7'd1;
			cur_q <= '0;
			stop_q <= '0;
			kind_q <= OP_CLR;
			val_q <= '0;
		end else if (st_q == F_IDLE) begin
			if (accept) begin
				case (req.kind)
					KIND_CLEAR: begin
						highest_q <= '0;
						expect_q <= 7'd1;
						kind_q <= OP_CLR;
						cur_q <= '0;
						stop_q <= '0;
						val_q <= '0;
						st_q <= F_EMIT;
					end
					KIND_SCAN_ELEM: begin
						if (in_range && req.feature_index > highest_q) begin
							highest_q <= req.feature_index;
						end
					end
					KIND_GATH_LABEL, KIND_SCALE_LABEL: begin
						expect_q <= 7'd1;
						kind_q <= (req.kind == KIND_GATH_LABEL) ? OP_LGATH : OP_LSCALE;
						cur_q <= '0;
						stop_q <= '0;
						val_q <= req.value;
						st_q <= F_EMIT;
					end
					KIND_GATH_ELEM, KIND_SCALE_ELEM: begin
						if (idx_ok) begin
							expect_q <= {1'b0, req.feature_index} + 7'd1;
							kind_q <= (req.kind == KIND_GATH_ELEM) ? OP_WIDEN : OP_EMIT;
							cur_q <= (expect_q < {1'b0, req.feature_index}) ?
								expect_q[5:0] : req.feature_index;
							stop_q <= req.feature_index;
							val_q <= req.value;
							st_q <= F_EMIT;
						end
					end
					default: begin
						expect_q <= 7'd1;
						if (expect_q <= {1'b0, highest_q}) begin
							kind_q <= (req.kind == KIND_GATH_END) ? OP_WIDEN : OP_EMIT;
							cur_q <= expect_q[5:0];
							stop_q <= highest_q;
							val_q <= '0;
							st_q <= F_EMIT;
						end
					end
				endcase
			end
		end else begin
			if (op_ready) begin
				if (at_stop) begin
					st_q <= F_IDLE;
				end else begin
					cur_q <= cur_q + 6'd1;
				end
			end
		end
	end
endmodule

// ===== hw/rtl/sms_queue.sv =====
// Short queue of table operations between the front and back ends.
module sms_queue (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_ready,
	input  sms_pkg::op_t push_op,
	output logic         pop_valid,
	input  logic         pop_ready,
	output sms_pkg::op_t pop_op
);
	import sms_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam logic [PW:0] DEPTH_C = (PW + 1)'(QUEUE_DEPTH);

	op_t           buf_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [PW:0]   cnt_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (cnt_q != DEPTH_C);
	assign pop_valid = (cnt_q != '0);
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;
	assign pop_op = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			buf_q[wr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + (PW + 1)'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - (PW + 1)'(1);
			end
		end
	end
endmodule

// ===== hw/rtl/sms_back.sv =====
// Back end: bound tables, scaling arithmetic and result ordering.
module sms_back #(
	parameter int FEATURE_SLOTS = sms_pkg::DEF_FEATURE_SLOTS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sms_pkg::cfg_t      cfg,
	input  logic               op_valid,
	output logic               op_ready,
	input  sms_pkg::op_t       op,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output sms_pkg::out_item_t rsp
);
	import sms_pkg::*;
	`include "sparse_min_max_feature_scaler_top_assert.svh"

	localparam int AW = (FEATURE_SLOTS > 1) ? $clog2(FEATURE_SLOTS) : 1;
	localparam logic [34:0] QSAT = 35'd1 << 34;

	typedef enum logic [6:0] {
		B_IDLE = 7'b0000001,
		B_RD   = 7'b0000010,
		B_MUL  = 7'b0000100,
		B_DCHK = 7'b0001000,
		B_DIV  = 7'b0010000,
		B_FIN  = 7'b0100000,
		B_POST = 7'b1000000
	} bstate_t;

	function automatic logic [32:0] mag33(input logic signed [32:0] x);
		mag33 = x[32] ? 33'(-x) : 33'(x);
	endfunction

	bstate_t            st_q;
	op_t                op_q;
	logic signed [31:0] top_mem [FEATURE_SLOTS];
	logic signed [31:0] bot_mem [FEATURE_SLOTS];
	logic signed [31:0] top_rd_q;
	logic signed [31:0] bot_rd_q;
	logic [FEATURE_SLOTS-1:0] vld_q;
	logic signed [31:0] ltop_q;
	logic signed [31:0] lbot_q;
	logic [65:0]        prod_q;
	logic [32:0]        span_mag_q;
	logic [32:0]        den_mag_q;
	logic [32:0]        rem_q;
	logic [34:0]        sh_q;
	logic [5:0]         cnt_q;
	logic               neg_q;
	logic signed [31:0] lo_q;
	logic               new_v_q;
	out_item_t          new_q;
	logic               hold_v_q;
	out_item_t          hold_q;
	logic               out_v_q;
	out_item_t          out_q;

	logic               pop;
	logic               is_lab;
	logic [AW-1:0]      waddr;
	logic signed [31:0] v;
	logic signed [31:0] b_top;
	logic signed [31:0] b_bot;
	logic signed [31:0] lo_sel;
	logic signed [31:0] hi_sel;
	logic signed [31:0] new_top;
	logic signed [31:0] new_bot;
	logic signed [32:0] span;
	logic signed [32:0] off;
	logic signed [32:0] den;
	logic               need_div;
	logic               have_res;
	logic signed [31:0] res_val;
	logic [33:0]        msum;
	logic [33:0]        rem2;
	logic               ge;
	logic [34:0]        qclamp;
	logic signed [35:0] sq;
	logic signed [36:0] rsum;
	logic signed [31:0] rsat;
	logic               out_free;
	logic               mem_we;
	logic               send;
	out_item_t          send_item;

	assign op_ready = (st_q == B_IDLE);
	assign pop = op_valid && op_ready;
	assign rsp_valid = out_v_q;
	assign rsp = out_q;
	assign out_free = !out_v_q || rsp_ready;

	assign waddr = op_q.slot[AW-1:0];
	assign v = op_q.value;
	assign is_lab = (op_q.kind == OP_LGATH) || (op_q.kind == OP_LSCALE);
	assign b_top = is_lab ? ltop_q : (vld_q[waddr] ? top_rd_q : I32_MIN);
	assign b_bot = is_lab ? lbot_q : (vld_q[waddr] ? bot_rd_q : I32_MAX);
	assign lo_sel = is_lab ? cfg.label_low : cfg.range_low;
	assign hi_sel = is_lab ? cfg.label_high : cfg.range_high;
	assign new_top = (v > b_top) ? v : b_top;
	assign new_bot = (v < b_bot) ? v : b_bot;
	assign span = {hi_sel[31], hi_sel} - {lo_sel[31], lo_sel};
	assign off = {v[31], v} - {b_bot[31], b_bot};
	assign den = {b_top[31], b_top} - {b_bot[31], b_bot};
	assign mem_we = (st_q == B_RD) && (op_q.kind == OP_WIDEN);

	always_comb begin
		need_div = 1'b0;
		have_res = 1'b0;
		res_val = v;
		case (op_q.kind)
			OP_EMIT: begin
				if (b_top != b_bot) begin
					if (v == b_bot) begin
						have_res = 1'b1;
						res_val = lo_sel;
					end else if (v == b_top) begin
						have_res = 1'b1;
						res_val = hi_sel;
					end else begin
						need_div = 1'b1;
					end
				end
			end
			OP_LSCALE: begin
				if (!cfg.label_scaling_on) begin
					have_res = 1'b1;
				end else if (v == b_bot) begin
					have_res = 1'b1;
					res_val = lo_sel;
				end else if (v == b_top) begin
					have_res = 1'b1;
					res_val = hi_sel;
				end else if (b_top == b_bot) begin
					have_res = 1'b1;
					res_val = lo_sel;
				end else begin
					need_div = 1'b1;
				end
			end
			default: begin
				have_res = 1'b0;
			end
		endcase
	end

	always_comb begin
		send = 1'b0;
		send_item = hold_q;
		if ((st_q == B_POST) && hold_v_q && out_free) begin
			if (new_v_q) begin
				send = 1'b1;
			end else if (op_q.fin) begin
				send = 1'b1;
				send_item.last = 1'b1;
			end
		end
	end

	assign msum = {1'b0, prod_q[65:33]} + (prod_q[0] ? {1'b0, span_mag_q} : 34'd0);
	assign rem2 = {rem_q, sh_q[34]};
	assign ge = rem2 >= {1'b0, den_mag_q};
	assign qclamp = (sh_q > QSAT) ? QSAT : sh_q;
	assign sq = neg_q ? -$signed({1'b0, qclamp}) : $signed({1'b0, qclamp});
	assign rsum = {{5{lo_q[31]}}, lo_q} + {sq[35], sq};

	always_comb begin
		if (rsum > 37'sh0_7fff_ffff) begin
			rsat = I32_MAX;
		end else if (rsum < -37'sh0_8000_0000) begin
			rsat = I32_MIN;
		end else begin
			rsat = rsum[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			top_rd_q <= top_mem[op.slot[AW-1:0]];
			bot_rd_q <= bot_mem[op.slot[AW-1:0]];
		end
		if (mem_we) begin
			top_mem[waddr] <= new_top;
			bot_mem[waddr] <= new_bot;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			op_q <= op;
		end
		if (st_q == B_RD) begin
			span_mag_q <= mag33(span);
			den_mag_q <= mag33(den);
			neg_q <= span[32] ^ off[32] ^ den[32];
			lo_q <= lo_sel;
			prod_q <= {33'd0, mag33(off)};
			cnt_q <= 6'd33;
		end else if (st_q == B_MUL) begin
			prod_q <= {msum, prod_q[32:1]};
			cnt_q <= cnt_q - 6'd1;
		end else if (st_q == B_DCHK) begin
			rem_q <= {2'b00, prod_q[65:35]};
			sh_q <= ({2'b00, prod_q[65:35]} >= den_mag_q) ? QSAT : prod_q[34:0];
			cnt_q <= 6'd35;
		end else if (st_q == B_DIV) begin
			rem_q <= ge ? 33'(rem2 - {1'b0, den_mag_q}) : rem2[32:0];
			sh_q <= {sh_q[33:0], ge};
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_IDLE;
			vld_q <= '0;
			ltop_q <= I32_MIN;
			lbot_q <= I32_MAX;
			new_v_q <= 1'b0;
			new_q <= '0;
			hold_v_q <= 1'b0;
			hold_q <= '0;
			out_v_q <= 1'b0;
			out_q <= '0;
		end else begin
			if (send) begin
				out_q <= send_item;
				out_v_q <= 1'b1;
			end else if (rsp_ready) begin
				out_v_q <= 1'b0;
			end
			case (st_q)
				B_IDLE: begin
					if (pop) begin
						st_q <= B_RD;
					end
				end
				B_RD: begin
					new_q.out_index <= op_q.slot;
					new_q.is_label <= is_lab;
					new_q.last <= 1'b0;
					new_q.out_value <= res_val;
					case (op_q.kind)
						OP_CLR: begin
							vld_q <= '0;
							ltop_q <= I32_MIN;
							lbot_q <= I32_MAX;
							st_q <= B_IDLE;
						end
						OP_WIDEN: begin
							vld_q[waddr] <= 1'b1;
							st_q <= B_IDLE;
						end
						OP_LGATH: begin
							ltop_q <= new_top;
							lbot_q <= new_bot;
							st_q <= B_IDLE;
						end
						default: begin
							if (need_div) begin
								st_q <= B_MUL;
							end else begin
								new_v_q <= have_res &&
									(is_lab || (res_val != 32'sd0));
								st_q <= B_POST;
							end
						end
					endcase
				end
				B_MUL: begin
					if (cnt_q == 6'd1) begin
						st_q <= B_DCHK;
					end
				end
				B_DCHK: begin
					st_q <= ({2'b00, prod_q[65:35]} >= den_mag_q) ? B_FIN : B_DIV;
				end
				B_DIV: begin
					if (cnt_q == 6'd1) begin
						st_q <= B_FIN;
					end
				end
				B_FIN: begin
					new_q.out_value <= rsat;
					new_v_q <= new_q.is_label || (rsat != 32'sd0);
					st_q <= B_POST;
				end
				B_POST: begin
					if (new_v_q) begin
						if (!hold_v_q) begin
							hold_q <= new_q;
							hold_v_q <= 1'b1;
							new_v_q <= 1'b0;
						end else if (out_free) begin
							hold_q <= new_q;
							new_v_q <= 1'b0;
						end
					end else if (op_q.fin && hold_v_q) begin
						if (out_free) begin
							hold_v_q <= 1'b0;
							st_q <= B_IDLE;
						end
					end else begin
						st_q <= B_IDLE;
					end
				end
				default: begin
					st_q <= B_IDLE;
				end
			endcase
		end
	end

	`SMS_ASSERT_IMP(a_div_den_nonzero, st_q == B_DIV, den_mag_q != 33'd0, "division by zero bound span")
	`SMS_ASSERT_IMP(a_idle_no_pending, st_q == B_IDLE, !new_v_q, "result pending while idle")
	`SMS_ASSERT_NXT(a_flush_last, (st_q == B_POST) && !new_v_q && op_q.fin && hold_v_q && out_free, out_v_q && out_q.last && !hold_v_q, "item end did not flush a last result")
endmodule

// ===== verif/sparse_min_max_feature_scaler_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the sparse min-max feature scaler: scan, gather and scale passes.
module sparse_min_max_feature_scaler_top_tb;
	import sms_pkg::*;

	localparam int SLOTS = DEF_FEATURE_SLOTS;
	localparam int WATCHDOG_LIMIT = 40000;
	localparam int SETTLE_CYCLES = 12000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	in_item_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	out_item_t rsp;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_idx = '0;
	logic [31:0] cfg_data = '0;

	in_item_t pending_items[$];
	out_item_t scaled_q[$];
	int send_gap_pct = 0;
	int stall_pct = 0;
	int fail_count = 0;
	int idle_cycles = 0;

	longint m_range_low, m_range_high, m_label_low, m_label_high;
	bit m_label_on;
	logic [5:0] m_highest;
	logic signed [31:0] m_ftop[SLOTS];
	logic signed [31:0] m_fbot[SLOTS];
	logic signed [31:0] m_ltop, m_lbot;
	int m_next_idx;

	sparse_min_max_feature_scaler_top dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic longint unsigned magnitude(longint x);
		return (x < 0) ? longint'(-x) : longint'(x);
	endfunction

	function automatic longint scale_between(longint v, longint lo, longint hi, longint bot,
			longint top);
		longint span, off, den, sq, r;
		bit neg;
		longint unsigned q;
		span = hi - lo;
		off = v - bot;
		den = top - bot;
		neg = ((span < 0) != (off < 0)) != (den < 0);
		q = (magnitude(span) * magnitude(off)) / magnitude(den);
		if (q > (64'd1 << 34))
			q = 64'd1 << 34;
		sq = neg ? -longint'(q) : longint'(q);
		r = lo + sq;
		if (r < longint'(I32_MIN))
			r = I32_MIN;
		if (r > longint'(I32_MAX))
			r = I32_MAX;
		return r;
	endfunction

	function automatic void add_result(int idx, longint val, bit lab);
		out_item_t o;
		o.out_index = idx[5:0];
		o.out_value = val[31:0];
		o.is_label = lab;
		o.last = 1'b0;
		scaled_q.push_back(o);
	endfunction

	function automatic void scale_feature(int i, longint v);
		longint bot, top, r;
		bot = m_fbot[i];
		top = m_ftop[i];
		if (top == bot)
			return;
		if (v == bot)
			r = m_range_low;
		else if (v == top)
			r = m_range_high;
		else
			r = scale_between(v, m_range_low, m_range_high, bot, top);
		if (r != 0)
			add_result(i, r, 1'b0);
	endfunction

	function automatic void widen_bounds(int i, logic signed [31:0] v);
		if (v > m_ftop[i])
			m_ftop[i] = v;
		if (v < m_fbot[i])
			m_fbot[i] = v;
	endfunction

	function automatic void clear_bounds();
		m_highest = '0;
		for (int i = 0; i < SLOTS; i++) begin
			m_ftop[i] = I32_MIN;
			m_fbot[i] = I32_MAX;
		end
		m_ltop = I32_MIN;
		m_lbot = I32_MAX;
		m_next_idx = 1;
	endfunction

	function automatic void predict_scaled(in_item_t it);
		int idx, start;
		longint v, r, bot, top;
		bit ok;
		out_item_t o;
		idx = it.feature_index;
		v = it.value;
		ok = idx >= 1 && idx < SLOTS && idx <= m_highest;
		start = scaled_q.size();
		case (it.kind)
			KIND_CLEAR: clear_bounds();
			KIND_SCAN_ELEM: begin
				if (idx < SLOTS && idx > m_highest)
					m_highest = idx[5:0];
			end
			KIND_GATH_LABEL: begin
				if (it.value > m_ltop)
					m_ltop = it.value;
				if (it.value < m_lbot)
					m_lbot = it.value;
				m_next_idx = 1;
			end
			KIND_GATH_ELEM: begin
				if (ok) begin
					for (int i = m_next_idx; i < idx; i++)
						widen_bounds(i, '0);
					widen_bounds(idx, it.value);
					m_next_idx = idx + 1;
				end
			end
			KIND_GATH_END: begin
				for (int i = m_next_idx; i <= m_highest && i < SLOTS; i++)
					widen_bounds(i, '0);
				m_next_idx = 1;
			end
			KIND_SCALE_LABEL: begin
				r = v;
				if (m_label_on) begin
					bot = m_lbot;
					top = m_ltop;
					if (v == bot)
						r = m_label_low;
					else if (v == top)
						r = m_label_high;
					else if (top == bot)
						r = m_label_low;
					else
						r = scale_between(v, m_label_low, m_label_high, bot, top);
				end
				add_result(0, r, 1'b1);
				m_next_idx = 1;
			end
			KIND_SCALE_ELEM: begin
				if (ok) begin
					for (int i = m_next_idx; i < idx; i++)
						scale_feature(i, 0);
					scale_feature(idx, v);
					m_next_idx = idx + 1;
				end
			end
			default: begin
				for (int i = m_next_idx; i <= m_highest && i < SLOTS; i++)
					scale_feature(i, 0);
				m_next_idx = 1;
			end
		endcase
		if (scaled_q.size() > start) begin
			o = scaled_q.pop_back();
			o.last = 1'b1;
			scaled_q.push_back(o);
		end
	endfunction

	task automatic report_mismatch(string msg);
		$display("ERROR %0t: %s", $realtime, msg);
		fail_count++;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready)
				predict_scaled(req);
			if (!req_valid || req_ready) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					req <= pending_items.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			rsp_ready <= ($urandom_range(99) >= stall_pct);
			if (rsp_valid && rsp_ready) begin
				if (scaled_q.size() == 0) begin
					report_mismatch($sformatf("unexpected result %p", rsp));
				end else begin
					want = scaled_q.pop_front();
					if (rsp.out_index !== want.out_index)
						report_mismatch($sformatf("out_index %0d, want %0d",
							rsp.out_index, want.out_index));
					if (rsp.out_value !== want.out_value)
						report_mismatch($sformatf("out_value %0d, want %0d (index %0d)",
							rsp.out_value, want.out_value, want.out_index));
					if (rsp.is_label !== want.is_label)
						report_mismatch($sformatf("is_label %b, want %b",
							rsp.is_label, want.is_label));
					if (rsp.last !== want.last)
						report_mismatch($sformatf("last %b, want %b (index %0d)",
							rsp.last, want.last, want.out_index));
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || cfg_we)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Timeout: no item moved for %0d cycles", idle_cycles);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		case (idx)
			REG_RANGE_LOW: m_range_low = longint'(signed'(data));
			REG_RANGE_HIGH: m_range_high = longint'(signed'(data));
			REG_LABEL_ON: m_label_on = data[0];
			REG_LABEL_LOW: m_label_low = longint'(signed'(data));
			default: m_label_high = longint'(signed'(data));
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_all(logic [31:0] lo, logic [31:0] hi, bit lab_on, logic [31:0] llo,
			logic [31:0] lhi);
		write_reg(REG_RANGE_LOW, lo);
		write_reg(REG_RANGE_HIGH, hi);
		write_reg(REG_LABEL_ON, {31'd0, lab_on});
		write_reg(REG_LABEL_LOW, llo);
		write_reg(REG_LABEL_HIGH, lhi);
	endtask

	task automatic wait_drained();
		while (pending_items.size() != 0 || req_valid || scaled_q.size() != 0) begin
			@(posedge clk);
			#1;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic put(logic [2:0] kind, int idx, logic [31:0] val);
		in_item_t it;
		it.kind = kind;
		it.feature_index = idx[5:0];
		it.value = val;
		pending_items.push_back(it);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(5))
			0: return I32_MIN;
			1: return I32_MAX;
			2: return '0;
			3: return $urandom_range(0, 200000) - 100000;
			default: return $urandom;
		endcase
	endfunction

	// One well-formed data set: scan, gather and scale over a few rows, with some noise.
	task automatic queue_data_set(output int count);
		int nrows, top_idx, nel;
		int idxs[4][8];
		int cnt[4];
		logic [31:0] labels[4];
		logic [31:0] vals[4][8];
		int first;
		first = pending_items.size();
		nrows = $urandom_range(1, 4);
		top_idx = ($urandom_range(9) == 0) ? 63 : $urandom_range(2, 12);
		for (int r = 0; r < nrows; r++) begin
			nel = 0;
			for (int i = 1; i <= top_idx && nel < 8; i++)
				if ($urandom_range(top_idx) < 4 || i == top_idx && r == 0) begin
					idxs[r][nel] = i;
					vals[r][nel] = pick_value();
					nel++;
				end
			cnt[r] = nel;
			labels[r] = pick_value();
		end
		put(KIND_CLEAR, $urandom_range(63), $urandom);
		for (int r = 0; r < nrows; r++)
			for (int e = 0; e < cnt[r]; e++)
				put(KIND_SCAN_ELEM, idxs[r][e], $urandom);
		for (int r = 0; r < nrows; r++) begin
			put(KIND_GATH_LABEL, $urandom_range(63), labels[r]);
			for (int e = 0; e < cnt[r]; e++)
				put(KIND_GATH_ELEM, idxs[r][e], vals[r][e]);
			put(KIND_GATH_END, $urandom_range(63), $urandom);
		end
		for (int r = 0; r < nrows; r++) begin
			put(KIND_SCALE_LABEL, $urandom_range(63),
				$urandom_range(3) == 0 ? pick_value() : labels[r]);
			for (int e = 0; e < cnt[r]; e++) begin
				if ($urandom_range(9) == 0)
					put(3'($urandom_range(7)), $urandom_range(63), pick_value());
				put(KIND_SCALE_ELEM, idxs[r][e],
					$urandom_range(3) == 0 ? pick_value() : vals[r][e]);
			end
			put(KIND_SCALE_END, $urandom_range(63), $urandom);
		end
		count = pending_items.size() - first;
	endtask

	task automatic random_phase(int target);
		int total, n;
		total = 0;
		while (total < target) begin
			queue_data_set(n);
			total += n;
		end
		wait_drained();
	endtask

	initial begin
		m_range_low = 0;
		m_range_high = 65536;
		m_label_on = 1'b0;
		m_label_low = 0;
		m_label_high = 65536;
		clear_bounds();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		put(KIND_CLEAR, 0, '0);
		put(KIND_SCAN_ELEM, 2, '0);
		put(KIND_SCAN_ELEM, 5, '0);
		put(KIND_SCAN_ELEM, 0, '0);
		put(KIND_GATH_LABEL, 0, I32_MAX);
		put(KIND_GATH_ELEM, 2, I32_MIN);
		put(KIND_GATH_ELEM, 5, I32_MAX);
		put(KIND_GATH_END, 0, '0);
		put(KIND_GATH_LABEL, 0, I32_MIN);
		put(KIND_GATH_ELEM, 5, '0);
		put(KIND_GATH_ELEM, 2, 32'd7);
		put(KIND_GATH_ELEM, 0, 32'd9);
		put(KIND_GATH_END, 0, '0);
		put(KIND_SCALE_LABEL, 0, 32'd123);
		put(KIND_SCALE_LABEL, 63, I32_MAX);
		put(KIND_SCALE_ELEM, 5, 32'd1);
		put(KIND_SCALE_ELEM, 1, 32'd5);
		put(KIND_SCALE_ELEM, 7, 32'd5);
		put(KIND_SCALE_END, 0, '0);
		put(KIND_SCAN_ELEM, 63, '0);
		put(KIND_SCALE_END, 0, '0);
		wait_drained();

		write_all(I32_MIN, I32_MAX, 1'b1, I32_MAX, I32_MIN);
		put(KIND_CLEAR, 0, '0);
		put(KIND_GATH_LABEL, 0, 32'd10);
		put(KIND_SCALE_LABEL, 0, 32'd11);
		put(KIND_SCALE_LABEL, 0, 32'd10);
		send_gap_pct = 67;
		random_phase(50);

		write_all(32'h0001_0000, 32'hffff_0000, 1'b1, -32'sd5, 32'sd5);
		send_gap_pct = 0;
		stall_pct = 67;
		random_phase(50);

		write_all($urandom, $urandom, 1'b1, $urandom, $urandom);
		send_gap_pct = 8;
		stall_pct = 8;
		random_phase(50);

		write_all(I32_MAX, I32_MIN, 1'b0, '0, '0);
		send_gap_pct = 0;
		stall_pct = 0;
		random_phase(50);

		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
